### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// clocked property, checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/rfbt_pkg.sv
// ----------------------------------------------------------------------------
// rfbt_pkg
// types and constants for the rfb client stream tap
// ----------------------------------------------------------------------------
package rfbt_pkg;

   typedef enum logic [2:0] {
      PH_VERSION    = 3'd0,
      PH_SECURITY   = 3'd1,
      PH_CLIENTINIT = 3'd2,
      PH_IDLE       = 3'd3,
      PH_HEADER     = 3'd4,
      PH_BODY       = 3'd5
   } phase_type;

   localparam logic [7:0] MSG_PIXEL_FORMAT = 8'd0;
   localparam logic [7:0] MSG_ENCODINGS    = 8'd2;
   localparam logic [7:0] MSG_UPDATE       = 8'd3;
   localparam logic [7:0] MSG_KEY          = 8'd4;
   localparam logic [7:0] MSG_POINTER      = 8'd5;
   localparam logic [7:0] MSG_CUT_TEXT     = 8'd6;

   localparam logic [1:0] KIND_POINTER     = 2'd0;
   localparam logic [1:0] KIND_UNKNOWN     = 2'd1;
   localparam logic [1:0] KIND_BAD_VERSION = 2'd2;

   localparam logic [3:0] VERSION_LAST     = 4'd11;
   localparam logic [3:0] MINOR_FIRST      = 4'd8;
   localparam logic [3:0] MINOR_LAST       = 4'd10;
   localparam logic [9:0] MINOR_SECURITY   = 10'd7;
   localparam logic [7:0] ASCII_ZERO       = 8'h30;
   localparam logic [7:0] ASCII_NINE       = 8'h39;

   localparam logic [33:0] BODY_PIXEL_FORMAT = 34'd19;
   localparam logic [33:0] BODY_UPDATE       = 34'd9;
   localparam logic [33:0] BODY_KEY          = 34'd7;

   typedef struct packed {
      phase_type   phase;
      logic        tap_active;
      logic [3:0]  phase_idx;
      logic [9:0]  minor;
      logic        digits_ok;
      logic [7:0]  msg_type;
      logic [3:0]  msg_idx;
      logic [31:0] len_acc;
      logic [33:0] remaining;
      logic [7:0]  held_buttons;
      logic [15:0] held_x;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_VERSION,
      tap_active:   1'b1,
      phase_idx:    4'd0,
      minor:        10'd0,
      digits_ok:    1'b1,
      msg_type:     8'd0,
      msg_idx:      4'd0,
      len_acc:      32'd0,
      remaining:    34'd0,
      held_buttons: 8'd0,
      held_x:       16'd0
   };

   typedef struct packed {
      logic        valid;
      logic [1:0]  kind;
      logic [7:0]  button_mask;
      logic [15:0] pointer_x;
      logic [15:0] pointer_y;
      logic [7:0]  bad_type;
   } result_type;

endpackage

### sv/rfbt_step.sv
// ----------------------------------------------------------------------------
// rfbt_step
// per-byte parser step: next tap state and the result of one item
// ----------------------------------------------------------------------------
module rfbt_step (
   input  rfbt_pkg::state_type  cur,
   input  logic                 cmd,
   input  logic [7:0]           data_byte,
   output rfbt_pkg::state_type  nxt,
   output rfbt_pkg::result_type res
);
   import rfbt_pkg::*;

   function automatic state_type start_body(state_type s, logic [33:0] n);
      state_type r;
      r = s;
      r.remaining = n;
      r.phase = (n == 34'd0) ? PH_IDLE : PH_BODY;
      return r;
   endfunction

   logic        is_digit;
   logic [9:0]  minor_next;
   logic [31:0] acc_shift;
   logic [33:0] rem_dec;

   assign is_digit   = (data_byte >= ASCII_ZERO) && (data_byte <= ASCII_NINE);
   assign minor_next = (cur.minor << 3) + (cur.minor << 1)
                     + {2'b00, data_byte - ASCII_ZERO};
   assign acc_shift  = {cur.len_acc[23:0], data_byte};
   assign rem_dec    = (cur.remaining != 34'd0) ? cur.remaining - 34'd1 : cur.remaining;

   // next state
   always_comb begin
      nxt = cur;
      if (cmd) begin
         nxt = STATE_RESET;
      end else if (cur.tap_active) begin
         case (cur.phase)
            PH_VERSION: begin
               if (cur.phase_idx >= MINOR_FIRST && cur.phase_idx <= MINOR_LAST) begin
                  if (is_digit) begin
                     nxt.minor = minor_next;
                  end else begin
                     nxt.digits_ok = 1'b0;
                  end
               end
               if (cur.phase_idx >= VERSION_LAST) begin
                  nxt.phase_idx = 4'd0;
                  if (!cur.digits_ok) begin
                     nxt.tap_active = 1'b0;
                  end else begin
                     nxt.phase = (cur.minor >= MINOR_SECURITY) ? PH_SECURITY : PH_CLIENTINIT;
                  end
               end else begin
                  nxt.phase_idx = cur.phase_idx + 4'd1;
               end
            end
            PH_SECURITY: begin
               nxt.phase = PH_CLIENTINIT;
            end
            PH_CLIENTINIT: begin
               nxt.phase = PH_IDLE;
            end
            PH_IDLE: begin
               nxt.msg_type = data_byte;
               nxt.msg_idx  = 4'd1;
               nxt.len_acc  = 32'd0;
               case (data_byte)
                  MSG_PIXEL_FORMAT: nxt = start_body(nxt, BODY_PIXEL_FORMAT);
                  MSG_UPDATE:       nxt = start_body(nxt, BODY_UPDATE);
                  MSG_KEY:          nxt = start_body(nxt, BODY_KEY);
                  MSG_ENCODINGS, MSG_POINTER, MSG_CUT_TEXT: nxt.phase = PH_HEADER;
                  default:          nxt.tap_active = 1'b0;
               endcase
            end
            PH_HEADER: begin
               nxt.msg_idx = cur.msg_idx + 4'd1;
               if (cur.msg_type == MSG_POINTER) begin
                  case (cur.msg_idx)
                     4'd1:    nxt.held_buttons = data_byte;
                     4'd2:    nxt.held_x = {data_byte, 8'h00};
                     4'd3:    nxt.held_x = cur.held_x | {8'h00, data_byte};
                     4'd4:    nxt.len_acc = {24'd0, data_byte};
                     default: nxt.phase = PH_IDLE;
                  endcase
               end else if (cur.msg_type == MSG_ENCODINGS) begin
                  if (cur.msg_idx == 4'd2) begin
                     nxt.len_acc = {24'd0, data_byte};
                  end else if (cur.msg_idx >= 4'd3) begin
                     nxt = start_body(nxt, {16'd0, cur.len_acc[7:0], data_byte, 2'b00});
                  end
               end else if (cur.msg_idx >= 4'd4) begin
                  nxt.len_acc = acc_shift;
                  if (cur.msg_idx >= 4'd7) begin
                     nxt = start_body(nxt, {2'b00, acc_shift});
                  end
               end
            end
            PH_BODY: begin
               nxt.remaining = rem_dec;
               if (rem_dec == 34'd0) begin
                  nxt.phase = PH_IDLE;
               end
            end
            default: begin
               nxt.phase = PH_IDLE;
            end
         endcase
      end
   end

   // result
   always_comb begin
      res = '0;
      if (!cmd && cur.tap_active) begin
         case (cur.phase)
            PH_VERSION: begin
               if (cur.phase_idx >= VERSION_LAST && !cur.digits_ok) begin
                  res.valid = 1'b1;
                  res.kind  = KIND_BAD_VERSION;
               end
            end
            PH_IDLE: begin
               if (!(data_byte inside {MSG_PIXEL_FORMAT, MSG_ENCODINGS, MSG_UPDATE,
                                       MSG_KEY, MSG_POINTER, MSG_CUT_TEXT})) begin
                  res.valid    = 1'b1;
                  res.kind     = KIND_UNKNOWN;
                  res.bad_type = data_byte;
               end
            end
            PH_HEADER: begin
               if (cur.msg_type == MSG_POINTER && !(cur.msg_idx inside {[4'd1:4'd4]})) begin
                  res.valid       = 1'b1;
                  res.kind        = KIND_POINTER;
                  res.button_mask = cur.held_buttons;
                  res.pointer_x   = cur.held_x;
                  res.pointer_y   = {cur.len_acc[7:0], data_byte};
               end
            end
            default: begin
               res = '0;
            end
         endcase
      end
   end

endmodule

### sv/rfb_client_stream_tap_top.sv
// ----------------------------------------------------------------------------
// rfb_client_stream_tap_top
// client-to-server rfb stream tap reporting pointer events and stop causes
// ----------------------------------------------------------------------------
// usage
//   req channel: one item per client byte (req_cmd 0) or a restart for a new
//   connection (req_cmd 1). taken when req_valid is high and req_stall low.
//   rsp channel: at most one item per request item, in order: a pointer
//   event (kind 0), an unknown message type (kind 1) or a bad version (kind 2).
//   a request item is taken into the input register, and its result goes
//   through the parser step into the result register, which drives rsp.
//   throughput: one item per cycle unless rsp_stall holds a waiting result,
//   set by the combinational parser step between the two registers.
//   reset: synchronous, active high; the parser returns to the version phase
//   with the tap active and both registers empty.
//   when rsp_stall is high with a result waiting, the input register still
//   fills; req_stall rises once it holds an item that cannot move on.
// ----------------------------------------------------------------------------
module rfb_client_stream_tap_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_button_mask,
   output logic [15:0] rsp_pointer_x,
   output logic [15:0] rsp_pointer_y,
   output logic [7:0]  rsp_bad_type
);
   import rfbt_pkg::*;

   `include "assert_macros.svh"

   logic       in_valid_ff, in_valid_in;
   logic       in_cmd_ff;
   logic [7:0] in_byte_ff;

   state_type  state_ff, state_in;
   state_type  step_nxt;
   result_type step_res;
   result_type rsp_ff, rsp_in;

   logic out_free;
   logic advance;
   logic req_take;

   rfbt_step u_step (
      .cur       (state_ff),
      .cmd       (in_cmd_ff),
      .data_byte (in_byte_ff),
      .nxt       (step_nxt),
      .res       (step_res)
   );

   assign out_free  = !rsp_ff.valid || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   assign in_valid_in = req_take || (in_valid_ff && !advance);
   assign state_in    = advance ? step_nxt : state_ff;

   always_comb begin
      rsp_in = rsp_ff;
      if (out_free) begin
         rsp_in       = step_res;
         rsp_in.valid = advance && step_res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= STATE_RESET;
         rsp_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
         rsp_ff      <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_cmd_ff  <= req_cmd;
         in_byte_ff <= req_data_byte;
      end
   end

   assign rsp_valid       = rsp_ff.valid;
   assign rsp_kind        = rsp_ff.kind;
   assign rsp_button_mask = rsp_ff.button_mask;
   assign rsp_pointer_x   = rsp_ff.pointer_x;
   assign rsp_pointer_y   = rsp_ff.pointer_y;
   assign rsp_bad_type    = rsp_ff.bad_type;

   `ASSERT_CLK(a_stop_deactivates, clock, reset, advance && step_res.valid && step_res.kind != KIND_POINTER |=> !state_ff.tap_active, "stop result without tap deactivation")
   `ASSERT_CLK(a_inactive_silent, clock, reset, in_valid_ff && !in_cmd_ff && !state_ff.tap_active |-> !step_res.valid, "result from inactive tap")
   `ASSERT_CLK(a_restart_clears, clock, reset, advance && in_cmd_ff |=> state_ff.phase == PH_VERSION && state_ff.tap_active && state_ff.phase_idx == 4'd0, "restart did not reset parser")
   `ASSERT_ALWAYS(a_stall_needs_item, clock, req_stall |-> in_valid_ff, "req_stall with empty input register")

endmodule

### sim/rfb_client_stream_tap_top_tb.sv
// ----------------------------------------------------------------------------
// rfb_client_stream_tap_top_tb
// self-checking bench for the rfb client stream tap
// ----------------------------------------------------------------------------
// A short table of hand-built bytes runs first: a restart, a version string
// at the security boundary, a pointer event at its extremes and an unknown
// message type. Random client sessions follow. Each session restarts the tap
// and sends a version string, good or broken; after a good one, well-formed
// messages of every type follow, with empty and huge bodies, ending in
// truncated or garbage bytes now and then. A bench-side parser model predicts
// each result not given by a table row, and results are compared field by
// field in order. Sender gaps and receiver stalls vary from phase to phase.
// ----------------------------------------------------------------------------
module rfb_client_stream_tap_top_tb;
   import rfbt_pkg::*;

   localparam int RANDOM_ITEMS = 1650;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_LIMIT  = 2000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  buttons;
      logic [15:0] x;
      logic [15:0] y;
      logic [7:0]  bad_type;
   } tap_event_t;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       typed;
      logic       t_got;
      tap_event_t t_ev;
   } stim_row_t;

   localparam tap_event_t NO_EVENT = '0;
   localparam tap_event_t PTR_EXTREME = '{KIND_POINTER, 8'hFF, 16'hFFFF, 16'h0000, 8'h00};
   localparam tap_event_t UNKNOWN_FF = '{KIND_UNKNOWN, 8'h00, 16'h0000, 16'h0000, 8'hFF};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_cmd;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_button_mask;
   logic [15:0] rsp_pointer_x;
   logic [15:0] rsp_pointer_y;
   logic [7:0]  rsp_bad_type;

   stim_row_t   req_row;
   tap_event_t  expected_events [$];
   stim_row_t   session_q [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          idle_pct = 0;
   int          stall_pct = 0;

   // parser copy
   phase_type   tp_phase;
   bit          tp_active;
   logic [3:0]  tp_vidx;
   logic [9:0]  tp_minor;
   bit          tp_digits_ok;
   logic [7:0]  tp_msg;
   logic [3:0]  tp_midx;
   logic [31:0] tp_len;
   logic [33:0] tp_left;
   logic [7:0]  tp_buttons;
   logic [15:0] tp_x;

   stim_row_t directed_rows [24] = '{
      '{1'b1, 8'hA5, 1'b1, 1'b0, NO_EVENT},
      '{1'b0, 8'h52, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h46, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h42, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h20, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h30, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h30, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h33, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h2E, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h30, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h30, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h37, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h0A, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h01, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, MSG_POINTER, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'hFF, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h00, 1'b0, 1'b0, NO_EVENT},
      '{1'b0, 8'h00, 1'b1, 1'b1, PTR_EXTREME},
      '{1'b0, 8'hFF, 1'b1, 1'b1, UNKNOWN_FF},
      '{1'b0, MSG_POINTER, 1'b1, 1'b0, NO_EVENT},
      '{1'b1, 8'h00, 1'b1, 1'b0, NO_EVENT}
   };

   logic [7:0] version_text [12] = '{8'h52, 8'h46, 8'h42, 8'h20, 8'h30, 8'h30,
                                     8'h33, 8'h2E, 8'h30, 8'h30, 8'h38, 8'h0A};
   logic [7:0] near_digits [5] = '{8'h20, 8'h2B, 8'h2D, 8'h2F, 8'h3A};
   logic [7:0] known_types [6] = '{MSG_PIXEL_FORMAT, MSG_ENCODINGS, MSG_UPDATE,
                                   MSG_KEY, MSG_POINTER, MSG_CUT_TEXT};
   int         idle_by_phase [4] = '{0, 46, 0, 32};
   int         stall_by_phase [4] = '{0, 0, 46, 32};

   rfb_client_stream_tap_top DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_button_mask (rsp_button_mask),
      .rsp_pointer_x   (rsp_pointer_x),
      .rsp_pointer_y   (rsp_pointer_y),
      .rsp_bad_type    (rsp_bad_type)
   );

   always #1 clock = ~clock;

   task automatic tap_clear();
      tp_phase     = PH_VERSION;
      tp_active    = 1'b1;
      tp_vidx      = '0;
      tp_minor     = '0;
      tp_digits_ok = 1'b1;
      tp_msg       = '0;
      tp_midx      = '0;
      tp_len       = '0;
      tp_left      = '0;
      tp_buttons   = '0;
      tp_x         = '0;
   endtask

   task automatic body_start(input logic [33:0] n);
      tp_left  = n;
      tp_phase = (n == 34'd0) ? PH_IDLE : PH_BODY;
   endtask

   task automatic tap_predict(input logic cmd, input logic [7:0] b,
                              output bit got, output tap_event_t ev);
      logic [3:0] idx;
      got = 1'b0;
      ev  = '0;
      if (cmd) begin
         tap_clear();
      end else if (tp_active) begin
         case (tp_phase)
            PH_VERSION: begin
               if (tp_vidx >= MINOR_FIRST && tp_vidx <= MINOR_LAST) begin
                  if (b >= ASCII_ZERO && b <= ASCII_NINE)
                     tp_minor = 10'(tp_minor * 10 + (b - ASCII_ZERO));
                  else
                     tp_digits_ok = 1'b0;
               end
               if (tp_vidx >= VERSION_LAST) begin
                  tp_vidx = '0;
                  if (!tp_digits_ok) begin
                     tp_active = 1'b0;
                     got       = 1'b1;
                     ev.kind   = KIND_BAD_VERSION;
                  end else begin
                     tp_phase = (tp_minor >= MINOR_SECURITY) ? PH_SECURITY : PH_CLIENTINIT;
                  end
               end else begin
                  tp_vidx = tp_vidx + 4'd1;
               end
            end
            PH_SECURITY:   tp_phase = PH_CLIENTINIT;
            PH_CLIENTINIT: tp_phase = PH_IDLE;
            PH_IDLE: begin
               tp_msg  = b;
               tp_midx = 4'd1;
               tp_len  = '0;
               case (b)
                  MSG_PIXEL_FORMAT: body_start(BODY_PIXEL_FORMAT);
                  MSG_UPDATE:       body_start(BODY_UPDATE);
                  MSG_KEY:          body_start(BODY_KEY);
                  MSG_ENCODINGS, MSG_POINTER, MSG_CUT_TEXT: tp_phase = PH_HEADER;
                  default: begin
                     tp_active   = 1'b0;
                     got         = 1'b1;
                     ev.kind     = KIND_UNKNOWN;
                     ev.bad_type = b;
                  end
               endcase
            end
            PH_HEADER: begin
               idx     = tp_midx;
               tp_midx = idx + 4'd1;
               if (tp_msg == MSG_POINTER) begin
                  case (idx)
                     4'd1: tp_buttons = b;
                     4'd2: tp_x = {b, 8'h00};
                     4'd3: tp_x = tp_x | {8'h00, b};
                     4'd4: tp_len = {24'd0, b};
                     default: begin
                        got        = 1'b1;
                        ev.kind    = KIND_POINTER;
                        ev.buttons = tp_buttons;
                        ev.x       = tp_x;
                        ev.y       = {tp_len[7:0], b};
                        tp_phase   = PH_IDLE;
                     end
                  endcase
               end else if (tp_msg == MSG_ENCODINGS) begin
                  if (idx == 4'd2)
                     tp_len = {24'd0, b};
                  else if (idx >= 4'd3)
                     body_start({16'd0, tp_len[7:0], b, 2'b00});
               end else if (idx >= 4'd4) begin
                  tp_len = {tp_len[23:0], b};
                  if (idx >= 4'd7)
                     body_start({2'b00, tp_len});
               end
            end
            PH_BODY: begin
               if (tp_left > 34'd0)
                  tp_left = tp_left - 34'd1;
               if (tp_left == 34'd0)
                  tp_phase = PH_IDLE;
            end
            default: tp_phase = PH_IDLE;
         endcase
      end
   endtask

   task automatic put(input logic cmd, input logic [7:0] d);
      session_q.push_back('{cmd, d, 1'b0, 1'b0, NO_EVENT});
   endtask

   task automatic put_noise(input int n);
      repeat (n) put(1'b0, 8'($urandom));
   endtask

   function automatic logic [7:0] edgy_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic build_session();
      int          i, n_msgs, m, pick, count, bad_pos;
      logic [9:0]  minor;
      logic [7:0]  b;
      logic [31:0] len;
      bit          bad;
      session_q.delete();
      put(1'b1, 8'($urandom));
      bad     = ($urandom_range(0, 9) == 0);
      bad_pos = $urandom_range(8, 10);
      minor   = '0;
      for (i = 0; i < 12; i++) begin
         if (i >= 8 && i <= 10) begin
            if (bad && (i == bad_pos || $urandom_range(0, 3) == 0)) begin
               if ($urandom_range(0, 1)) begin
                  b = near_digits[$urandom_range(0, 4)];
               end else begin
                  b = 8'($urandom);
                  if (b >= ASCII_ZERO && b <= ASCII_NINE)
                     b = b ^ 8'h80;
               end
               put(1'b0, b);
            end else begin
               b = (i < 10 && $urandom_range(0, 1)) ? 8'd0 : 8'($urandom_range(0, 9));
               minor = 10'(minor * 10 + b);
               put(1'b0, ASCII_ZERO + b);
            end
         end else begin
            put(1'b0, $urandom_range(0, 1) ? version_text[i] : 8'($urandom));
         end
      end
      if (bad) begin
         put_noise($urandom_range(0, 3));
         return;
      end
      if (minor >= MINOR_SECURITY)
         put_noise(1);
      put_noise(1);
      n_msgs = $urandom_range(1, 12);
      for (m = 0; m < n_msgs; m++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            put(1'b0, MSG_POINTER);
            for (i = 0; i < 5; i++)
               put(1'b0, edgy_byte());
         end else if (pick < 45) begin
            put(1'b0, MSG_KEY);
            put_noise(7);
         end else if (pick < 53) begin
            put(1'b0, MSG_UPDATE);
            put_noise(9);
         end else if (pick < 59) begin
            put(1'b0, MSG_PIXEL_FORMAT);
            put_noise(19);
         end else if (pick < 70) begin
            count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 3);
            put(1'b0, MSG_ENCODINGS);
            put_noise(1);
            put(1'b0, 8'(count >> 8));
            put(1'b0, 8'(count));
            // long lists are cut short by the next restart
            if (count > 3) begin
               put_noise($urandom_range(0, 8));
               return;
            end
            put_noise(count * 4);
         end else if (pick < 82) begin
            len = ($urandom_range(0, 9) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5));
            put(1'b0, MSG_CUT_TEXT);
            put_noise(3);
            for (i = 3; i >= 0; i--)
               put(1'b0, len[8*i +: 8]);
            if (len > 32'd5) begin
               put_noise($urandom_range(0, 8));
               return;
            end
            put_noise(int'(len));
         end else if (pick < 90) begin
            put(1'b0, known_types[$urandom_range(0, 5)]);
            put_noise($urandom_range(0, 4));
            return;
         end else if (pick < 95) begin
            put(1'b0, ($urandom_range(0, 7) == 0) ? 8'd1 : 8'($urandom_range(7, 255)));
            put_noise($urandom_range(0, 3));
            return;
         end else begin
            put_noise(1);
            return;
         end
      end
   endtask

   task automatic send_row(input stim_row_t r);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_cmd       <= r.cmd;
      req_data_byte <= r.data;
      req_row       <= r;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] seen);
      if (want !== seen) begin
         $error("%s: expected %0h, got %0h", name, want, seen);
         mismatches++;
      end
   endtask

   always @(posedge clock)
      rsp_stall <= ($urandom_range(0, 99) < stall_pct);

   always @(posedge clock) begin : watch
      bit         got;
      tap_event_t ev;
      tap_event_t want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            tap_predict(req_cmd, req_data_byte, got, ev);
            if (req_row.typed) begin
               got = req_row.t_got;
               ev  = req_row.t_ev;
            end
            if (got)
               expected_events.push_back(ev);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_events.size() == 0) begin
               $error("result with none expected: kind %0d", rsp_kind);
               mismatches++;
            end else begin
               want = expected_events.pop_front();
               check_field("kind", 16'(want.kind), 16'(rsp_kind));
               check_field("button_mask", 16'(want.buttons), 16'(rsp_button_mask));
               check_field("pointer_x", want.x, rsp_pointer_x);
               check_field("pointer_y", want.y, rsp_pointer_y);
               check_field("bad_type", 16'(want.bad_type), 16'(rsp_bad_type));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin : main
      int i, ph, sent, waited;
      tap_clear();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_cmd       = 1'b0;
      req_data_byte = 8'h00;
      req_row       = '0;
      rsp_stall     = 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      for (i = 0; i < 24; i++)
         send_row(directed_rows[i]);
      for (ph = 0; ph < 4; ph++) begin
         idle_pct  = idle_by_phase[ph];
         stall_pct = stall_by_phase[ph];
         sent      = 0;
         while (sent < RANDOM_ITEMS / 4) begin
            build_session();
            sent += session_q.size();
            while (session_q.size() > 0)
               send_row(session_q.pop_front());
         end
      end
      req_valid <= 1'b0;
      waited = 0;
      while (expected_events.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (8) @(posedge clock);
      if (expected_events.size() != 0) begin
         $error("%0d results never arrived", expected_events.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
